// ===== design/lks_pkg.sv =====
// lks_pkg: shared types and constants of the lwe key switch block
// no dependencies; imported by the interfaces and all design modules
package lks_pkg;

    localparam int WORD_W     = 64;
    localparam int OP_W       = 2;
    localparam int ROW_W      = 6;
    localparam int LEVEL_W    = 3;
    localparam int COL_W      = 6;
    localparam int OUT_IDX_W  = 5;
    localparam int IN_DIM_W   = 7;
    localparam int TGT_DIM_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [IN_DIM_W-1:0]  IN_DIM_RST  = 7'd64;
    localparam logic [TGT_DIM_W-1:0] TGT_DIM_RST = 6'd32;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BEGIN = 2'd1;
    localparam logic [OP_W-1:0] OP_COEF  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DIM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DIM = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic key_write;
        logic begin_op;
        logic coef_load;
        logic digit_shift;
        logic clear_we;
        logic issue;
        logic issue_body;
        logic out_load;
        logic out_body;
    } lks_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic digit_zero;
        logic load_ok;
        logic out_free;
    } lks_status_t;

endpackage

// ===== design/lks_ifs.sv =====
// lks_ifs: valid/ready channel interfaces of the lwe key switch block
// depends on lks_pkg
interface lks_in_if import lks_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [ROW_W-1:0]     key_row;
    logic [LEVEL_W-1:0]   key_level;
    logic [COL_W-1:0]     key_col;
    logic [WORD_W-1:0]    value;

    modport source (output valid, operation, key_row, key_level, key_col, value, input ready);
    modport sink (input valid, operation, key_row, key_level, key_col, value, output ready);
endinterface

interface lks_out_if import lks_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] out_index;
    logic                 is_body;
    logic [WORD_W-1:0]    out_value;
    logic                 last;

    modport source (output valid, out_index, is_body, out_value, last, input ready);
    modport sink (input valid, out_index, is_body, out_value, last, output ready);
endinterface

interface lks_cfg_if import lks_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/lwe_key_switch_unit.sv =====
// lwe_key_switch_unit: top level of the lwe key switch block
// depends on lks_pkg, lks_ifs, lks_ctrl, lks_datapath
//
//  channel  role   beat contents
//  in       sink   operation, key_row, key_level, key_col, value
//  out      source out_index, is_body, out_value, last
//  cfg      sink   index, data (0 coefficient count, 1 mask word count)
//
// key load: a single write; begin: clears all OUT_DIM words of the mask memory
// mask coefficient: per zero digit a shift, per nonzero digit a pass over the mask words and body,
//   one multiply-subtract per cycle through the mask memory read and write ports
// emit: a read state and a load state per result word; the load waits while out is stalled
// in is taken only while the sequencer is idle; cfg is always ready
// reset: rst_n asynchronous, no memory clearing pass
module lwe_key_switch_unit import lks_pkg::*; #(
    parameter int IN_DIM    = 64,
    parameter int OUT_DIM   = 32,
    parameter int BASE_BITS = 8,
    parameter int LEVELS    = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    lks_in_if.sink    in,
    lks_out_if.source out,
    lks_cfg_if.sink   cfg
);

    localparam int JW  = $clog2(OUT_DIM + 1);
    localparam int KAW = $clog2(IN_DIM * LEVELS * (OUT_DIM + 1));

    lks_cmd_t    cmd;
    lks_status_t status;
    logic [JW-1:0]  idx;
    logic [KAW-1:0] key_addr;

    assign cfg.ready = 1'b1;

    lks_ctrl #(
        .IN_DIM    (IN_DIM),
        .OUT_DIM   (OUT_DIM),
        .BASE_BITS (BASE_BITS),
        .LEVELS    (LEVELS),
        .JW        (JW),
        .KAW       (KAW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in.valid),
        .in_ready     (in.ready),
        .in_operation (in.operation),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .status       (status),
        .cmd          (cmd),
        .idx          (idx),
        .key_addr     (key_addr)
    );

    lks_datapath #(
        .IN_DIM    (IN_DIM),
        .OUT_DIM   (OUT_DIM),
        .BASE_BITS (BASE_BITS),
        .LEVELS    (LEVELS),
        .JW        (JW),
        .KAW       (KAW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .idx       (idx),
        .key_addr  (key_addr),
        .key_row   (in.key_row),
        .key_level (in.key_level),
        .key_col   (in.key_col),
        .value     (in.value),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .out_index (out.out_index),
        .is_body   (out.is_body),
        .out_value (out.out_value),
        .last      (out.last)
    );

endmodule

// ===== design/lks_ctrl.sv =====
// lks_ctrl: sequencer of the lwe key switch block (config registers, counters, fsm)
// depends on lks_pkg; drives lks_datapath through command and status structs
module lks_ctrl import lks_pkg::*; #(
    parameter int IN_DIM    = 64,
    parameter int OUT_DIM   = 32,
    parameter int BASE_BITS = 8,
    parameter int LEVELS    = 8,
    parameter int JW        = $clog2(OUT_DIM + 1),
    parameter int KAW       = $clog2(IN_DIM * LEVELS * (OUT_DIM + 1))
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       in_operation,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  lks_status_t           status,
    output lks_cmd_t              cmd,
    output logic [JW-1:0]         idx,
    output logic [KAW-1:0]        key_addr
);

    localparam int NCOLS     = OUT_DIM + 1;
    localparam int ROW_WORDS = LEVELS * NCOLS;
    localparam int NUM_LEV   = (LEVELS < WORD_W / BASE_BITS) ? LEVELS : WORD_W / BASE_BITS;
    localparam int LVW       = $clog2(NUM_LEV + 1);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CLEAR   = 7'b0000010,
        S_LEVEL   = 7'b0000100,
        S_RUN     = 7'b0001000,
        S_DRAIN   = 7'b0010000,
        S_EMIT_RD = 7'b0100000,
        S_EMIT_LD = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [IN_DIM_W-1:0]   in_dim_reg;
    logic [TGT_DIM_W-1:0]  tgt_dim_reg;
    logic [IN_DIM_W-1:0]   count_reg, count_next;
    logic                  active_reg, active_next;
    logic [JW-1:0]         j_reg, j_next;
    logic [LVW-1:0]        lev_reg, lev_next;
    logic [KAW-1:0]        key_base_reg, key_base_next;
    logic                  drain_reg, drain_next;
    logic [IN_DIM_W-1:0]   eff_in;
    logic [JW-1:0]         eff_td;
    logic [IN_DIM_W-1:0]   count_inc;
    logic                  at_body;
    logic                  accept;

    always_comb
    begin
        if (32'(in_dim_reg) > IN_DIM)
            eff_in = IN_DIM_W'(IN_DIM);
        else
            eff_in = in_dim_reg;
        if (32'(tgt_dim_reg) > OUT_DIM)
            eff_td = JW'(OUT_DIM);
        else
            eff_td = JW'(tgt_dim_reg);
    end

    assign count_inc = count_reg + 7'd1;
    assign at_body   = (j_reg == eff_td);
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign idx       = j_reg;
    assign key_addr  = key_base_reg + (at_body ? KAW'(OUT_DIM) : KAW'(j_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_dim_reg  <= IN_DIM_RST;
            tgt_dim_reg <= TGT_DIM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_INPUT_DIM:  in_dim_reg  <= cfg_data;
                CFG_TARGET_DIM: tgt_dim_reg <= cfg_data[TGT_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        active_next   = active_reg;
        j_next        = j_reg;
        lev_next      = lev_reg;
        key_base_next = key_base_reg;
        drain_next    = drain_reg;
        cmd           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_operation)
                        OP_LOAD:
                            cmd.key_write = status.load_ok;
                        OP_BEGIN:
                        begin
                            cmd.begin_op = 1'b1;
                            count_next   = '0;
                            active_next  = 1'b1;
                            j_next       = '0;
                            state_next   = S_CLEAR;
                        end
                        OP_COEF:
                        begin
                            if (active_reg)
                            begin
                                if (count_reg < eff_in)
                                begin
                                    cmd.coef_load = 1'b1;
                                    key_base_next = KAW'(32'(count_reg) * ROW_WORDS);
                                    lev_next      = '0;
                                    state_next    = S_LEVEL;
                                end
                                else
                                begin
                                    count_next = count_inc;
                                    if (count_inc >= eff_in)
                                    begin
                                        active_next = 1'b0;
                                        j_next      = '0;
                                        state_next  = S_EMIT_RD;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (j_reg == JW'(OUT_DIM - 1))
                begin
                    j_next = '0;
                    if (eff_in == '0)
                    begin
                        active_next = 1'b0;
                        state_next  = S_EMIT_RD;
                    end
                    else
                        state_next = S_IDLE;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            S_LEVEL:
            begin
                if (lev_reg == LVW'(NUM_LEV))
                begin
                    count_next = count_inc;
                    if (count_inc >= eff_in)
                    begin
                        active_next = 1'b0;
                        j_next      = '0;
                        state_next  = S_EMIT_RD;
                    end
                    else
                        state_next = S_IDLE;
                end
                else if (status.digit_zero)
                begin
                    cmd.digit_shift = 1'b1;
                    lev_next        = lev_reg + 1'b1;
                    key_base_next   = key_base_reg + KAW'(NCOLS);
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.issue      = 1'b1;
                cmd.issue_body = at_body;
                if (at_body)
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            S_DRAIN:
            begin
                // wait for the last write-back before the next level reads again
                if (drain_reg)
                begin
                    cmd.digit_shift = 1'b1;
                    lev_next        = lev_reg + 1'b1;
                    key_base_next   = key_base_reg + KAW'(NCOLS);
                    state_next      = S_LEVEL;
                end
                else
                    drain_next = 1'b1;
            end
            S_EMIT_RD:
                state_next = S_EMIT_LD;
            S_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_body = at_body;
                    if (at_body)
                        state_next = S_IDLE;
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            active_reg   <= 1'b0;
            j_reg        <= '0;
            lev_reg      <= '0;
            key_base_reg <= '0;
            drain_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            active_reg   <= active_next;
            j_reg        <= j_next;
            lev_reg      <= lev_next;
            key_base_reg <= key_base_next;
            drain_reg    <= drain_next;
        end
    end

endmodule

// ===== design/lks_datapath.sv =====
// lks_datapath: key memory, mask accumulator memory, multiply-subtract pipe, output register
// depends on lks_pkg; commanded by lks_ctrl
module lks_datapath import lks_pkg::*; #(
    parameter int IN_DIM    = 64,
    parameter int OUT_DIM   = 32,
    parameter int BASE_BITS = 8,
    parameter int LEVELS    = 8,
    parameter int JW        = $clog2(OUT_DIM + 1),
    parameter int KAW       = $clog2(IN_DIM * LEVELS * (OUT_DIM + 1))
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lks_cmd_t             cmd,
    output lks_status_t          status,
    input  logic [JW-1:0]        idx,
    input  logic [KAW-1:0]       key_addr,
    input  logic [ROW_W-1:0]     key_row,
    input  logic [LEVEL_W-1:0]   key_level,
    input  logic [COL_W-1:0]     key_col,
    input  logic [WORD_W-1:0]    value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_IDX_W-1:0] out_index,
    output logic                 is_body,
    output logic [WORD_W-1:0]    out_value,
    output logic                 last
);

    localparam int NCOLS     = OUT_DIM + 1;
    localparam int ROW_WORDS = LEVELS * NCOLS;
    localparam int KEY_WORDS = IN_DIM * ROW_WORDS;
    localparam int IDX_W     = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;

    logic [WORD_W-1:0]    key_mem [KEY_WORDS];
    logic [WORD_W-1:0]    mask_mem [OUT_DIM];
    logic [WORD_W-1:0]    key_q_reg;
    logic [WORD_W-1:0]    mask_q_reg;
    logic [WORD_W-1:0]    coef_reg;
    logic [WORD_W-1:0]    body_reg;
    logic [BASE_BITS-1:0] digit;
    logic [KAW-1:0]       load_addr;

    logic                 s1_valid_reg;
    logic                 s1_body_reg;
    logic [IDX_W-1:0]     s1_idx_reg;
    logic                 s2_valid_reg;
    logic                 s2_body_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic [WORD_W-1:0]    prod_reg;
    logic [WORD_W-1:0]    acc_reg;
    logic [WORD_W-1:0]    diff;

    logic                 mask_we;
    logic [IDX_W-1:0]     mask_waddr;
    logic [WORD_W-1:0]    mask_wdata;

    logic                 out_valid_reg;
    logic [OUT_IDX_W-1:0] out_index_reg;
    logic                 is_body_reg;
    logic [WORD_W-1:0]    out_value_reg;

    assign digit     = coef_reg[WORD_W-1 -: BASE_BITS];
    assign load_addr = KAW'(32'(key_row) * ROW_WORDS + 32'(key_level) * NCOLS + 32'(key_col));
    assign diff      = acc_reg - prod_reg;

    assign status.digit_zero = (digit == '0);
    assign status.load_ok    = (32'(key_row) < IN_DIM) && (32'(key_level) < LEVELS)
                               && (32'(key_col) <= OUT_DIM);
    assign status.out_free   = !out_valid_reg || out_ready;

    // key table: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.key_write)
            key_mem[load_addr] <= value;
        key_q_reg <= key_mem[key_addr];
    end

    always_comb
    begin
        mask_we    = 1'b0;
        mask_waddr = idx[IDX_W-1:0];
        mask_wdata = '0;
        if (cmd.clear_we)
            mask_we = 1'b1;
        else if (s2_valid_reg && !s2_body_reg)
        begin
            mask_we    = 1'b1;
            mask_waddr = s2_idx_reg;
            mask_wdata = diff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
            mask_mem[mask_waddr] <= mask_wdata;
        mask_q_reg <= mask_mem[idx[IDX_W-1:0]];
    end

    // coefficient shifts up one digit per level, top digit first
    always_ff @(posedge clk)
    begin
        if (cmd.coef_load)
            coef_reg <= value;
        else if (cmd.digit_shift)
            coef_reg <= coef_reg << BASE_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_op)
            body_reg <= value;
        else if (s2_valid_reg && s2_body_reg)
            body_reg <= diff;
    end

    always_ff @(posedge clk)
    begin
        s1_body_reg <= cmd.issue_body;
        s1_idx_reg  <= idx[IDX_W-1:0];
        s2_body_reg <= s1_body_reg;
        s2_idx_reg  <= s1_idx_reg;
        prod_reg    <= key_q_reg * {{(WORD_W - BASE_BITS){1'b0}}, digit};
        acc_reg     <= s1_body_reg ? body_reg : mask_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg <= cmd.out_body ? '0 : OUT_IDX_W'(idx);
            is_body_reg   <= cmd.out_body;
            out_value_reg <= cmd.out_body ? body_reg : mask_q_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign is_body   = is_body_reg;
    assign out_value = out_value_reg;
    assign last      = is_body_reg;

endmodule

// ===== design/lks_checker.sv =====
// lks_checker: port-level assertions for lwe_key_switch_unit, attached by bind
// depends on lks_pkg
module lks_checker import lks_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [OP_W-1:0]      in_operation,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [OUT_IDX_W-1:0] out_index,
    input logic                 is_body,
    input logic                 last
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out beat dropped while stalled");

    a_last_is_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == is_body))
        else $error("last and is_body disagree");

    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_body |-> (out_index == '0))
        else $error("body beat with nonzero index");

    // begin starts the accumulator clear, input closed next cycle
    a_begin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_operation == OP_BEGIN) |=> !in_ready)
        else $error("input open right after begin");

endmodule

bind lwe_key_switch_unit lks_checker u_lks_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in.valid),
    .in_ready     (in.ready),
    .in_operation (in.operation),
    .out_valid    (out.valid),
    .out_ready    (out.ready),
    .out_index    (out.out_index),
    .is_body      (out.is_body),
    .last         (out.last)
);
